[design/mm4_pkg.sv]
package mm4_pkg;

  localparam int DIM_DEFAULT        = 4;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int FRAC_BITS_DEFAULT  = 16;

  localparam int PORT_W      = 32;
  localparam int INDEX_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } back_state_t;

endpackage

[design/matrix4_multiply.sv]
// channel   dir   handshake          beat fields
// load      in    start, busy        left_value, right_value
// product   out   strobe             product_value, product_index, is_last
//
// loads are taken one per cycle into a two-beat queue; busy rises when it fills
// the item that completes the matrices starts DIM^3 multiply-accumulate steps,
// one per cycle on a single multiplier
// one product beat per output cell, once its last step has passed the store read,
// product, accumulator and output registers
// rst clears the load count, queue and sequencer; the receiver cannot stall
module matrix4_multiply import mm4_pkg::*; #(
  parameter int DIM        = DIM_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [PORT_W-1:0]  left_value,
  input  logic [PORT_W-1:0]  right_value,
  output logic               strobe,
  output logic [PORT_W-1:0]  product_value,
  output logic [INDEX_W-1:0] product_index,
  output logic               is_last
);

  localparam int QW = 1 + $clog2(DIM * DIM) + 2 * DATA_WIDTH;

  logic          push;
  logic [QW-1:0] push_data;
  logic          pop;
  logic [QW-1:0] pop_data;
  logic          full;
  logic          empty;

  mm4_front #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .QW         (QW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .left_value  (left_value),
    .right_value (right_value),
    .full        (full),
    .push        (push),
    .push_data   (push_data)
  );

  mm4_queue #(
    .QW (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  mm4_back #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .QW         (QW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .pop_data      (pop_data),
    .pop           (pop),
    .strobe        (strobe),
    .product_value (product_value),
    .product_index (product_index),
    .is_last       (is_last)
  );

endmodule

[design/mm4_front.sv]
module mm4_front import mm4_pkg::*; #(
  parameter int DIM        = DIM_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int QW         = 1 + $clog2(DIM * DIM) + 2 * DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [PORT_W-1:0]    left_value,
  input  logic [PORT_W-1:0]    right_value,
  input  logic                 full,
  output logic                 push,
  output logic [QW-1:0]        push_data
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);

  logic [AW-1:0] load_count;
  logic [AW-1:0] load_count_next;
  logic          load_last;

  assign busy      = full;
  assign push      = start && !full;
  assign load_last = (load_count == AW'(CELLS - 1));

  // beat: completion flag, store address, left element, right element
  assign push_data = {load_last, load_count,
                      left_value[DATA_WIDTH-1:0], right_value[DATA_WIDTH-1:0]};

  always_comb begin
    load_count_next = load_count;
    if (push) begin
      load_count_next = load_last ? '0 : load_count + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else begin
      load_count <= load_count_next;
    end
  end

endmodule

[design/mm4_queue.sv]
module mm4_queue import mm4_pkg::*; #(
  parameter int QW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] push_data,
  input  logic          pop,
  output logic [QW-1:0] pop_data,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [QW-1:0]  slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/mm4_back.sv]
module mm4_back import mm4_pkg::*; #(
  parameter int DIM        = DIM_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
  parameter int QW         = 1 + $clog2(DIM * DIM) + 2 * DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  logic [QW-1:0]      pop_data,
  output logic               pop,
  output logic               strobe,
  output logic [PORT_W-1:0]  product_value,
  output logic [INDEX_W-1:0] product_index,
  output logic               is_last
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(DIM);
  localparam int MW    = 2 * DATA_WIDTH;
  localparam int PW    = MW - FRAC_BITS;
  localparam int ACC_W = PW + CW + 1;

  typedef struct packed {
    logic          valid;
    logic          first;
    logic          fin;
    logic          last;
    logic [AW-1:0] idx;
  } tag_t;

  logic [DATA_WIDTH-1:0] left_mem  [CELLS];
  logic [DATA_WIDTH-1:0] right_mem [CELLS];

  logic                  q_last;
  logic [AW-1:0]         q_addr;
  logic [DATA_WIDTH-1:0] q_left;
  logic [DATA_WIDTH-1:0] q_right;

  back_state_t state;
  back_state_t state_next;
  logic [CW-1:0] row;
  logic [CW-1:0] row_next;
  logic [CW-1:0] col;
  logic [CW-1:0] col_next;
  logic [CW-1:0] step;
  logic [CW-1:0] step_next;

  logic [AW-1:0] left_addr;
  logic [AW-1:0] right_addr;
  tag_t          tag0;
  tag_t          tag1;
  tag_t          tag2;
  tag_t          tag3;

  logic [DATA_WIDTH-1:0]   left_rd;
  logic [DATA_WIDTH-1:0]   right_rd;
  logic signed [MW-1:0]    prod;
  logic signed [PW-1:0]    shifted;
  logic signed [ACC_W-1:0] acc;
  logic [DATA_WIDTH-1:0]   sat;
  logic [AW+INDEX_W-1:0]   idx_ext;

  assign q_last  = pop_data[QW-1];
  assign q_addr  = pop_data[QW-2 -: AW];
  assign q_left  = pop_data[MW-1 -: DATA_WIDTH];
  assign q_right = pop_data[DATA_WIDTH-1:0];

  assign left_addr  = AW'(AW'(row) * AW'(DIM) + AW'(step));
  assign right_addr = AW'(AW'(step) * AW'(DIM) + AW'(col));

  always_comb begin
    state_next = state;
    row_next   = row;
    col_next   = col;
    step_next  = step;
    pop        = 1'b0;
    tag0       = '0;
    case (state)
      ST_IDLE: begin
        pop = !empty;
        if (pop && q_last) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        tag0.valid = 1'b1;
        tag0.first = (step == '0);
        tag0.fin   = (step == CW'(DIM - 1));
        tag0.last  = tag0.fin && (row == CW'(DIM - 1)) && (col == CW'(DIM - 1));
        tag0.idx   = AW'(AW'(row) * AW'(DIM) + AW'(col));
        if (step == CW'(DIM - 1)) begin
          step_next = '0;
          if (col == CW'(DIM - 1)) begin
            col_next = '0;
            if (row == CW'(DIM - 1)) begin
              row_next   = '0;
              state_next = ST_IDLE;
            end else begin
              row_next = row + CW'(1);
            end
          end else begin
            col_next = col + CW'(1);
          end
        end else begin
          step_next = step + CW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      row   <= '0;
      col   <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      row   <= row_next;
      col   <= col_next;
      step  <= step_next;
    end
  end

  // element stores
  always_ff @(posedge clk) begin
    if (pop) begin
      left_mem[q_addr]  <= q_left;
      right_mem[q_addr] <= q_right;
    end
    left_rd  <= left_mem[left_addr];
    right_rd <= right_mem[right_addr];
  end

  // multiply-accumulate pipeline
  assign shifted = prod[MW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    prod <= $signed(left_rd) * $signed(right_rd);
    acc  <= tag2.first ? ACC_W'(shifted) : acc + ACC_W'(shifted);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag1 <= tag0;
      tag2 <= tag1;
      tag3 <= tag2;
    end
  end

  // saturate to the data width
  always_comb begin
    if (&acc[ACC_W-1:DATA_WIDTH-1] || ~|acc[ACC_W-1:DATA_WIDTH-1]) begin
      sat = acc[DATA_WIDTH-1:0];
    end else if (acc[ACC_W-1]) begin
      sat = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

  assign idx_ext = {{INDEX_W{1'b0}}, tag3.idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      is_last <= 1'b0;
    end else begin
      strobe  <= tag3.valid && tag3.fin;
      is_last <= tag3.valid && tag3.fin && tag3.last;
    end
  end

  always_ff @(posedge clk) begin
    product_value <= PORT_W'($signed(sat));
    product_index <= idx_ext[INDEX_W-1:0];
  end

  a_last_has_strobe : assert property (@(posedge clk) disable iff (rst)
    is_last |-> strobe)
    else $error("last flag without result strobe");

  a_strobe_spacing : assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results closer than one accumulation apart");

  a_no_load_in_run : assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |=> !($past(pop)))
    else $error("store written while products are being formed");

  a_last_index : assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |-> (product_index == idx_ext[INDEX_W-1:0] ||
                             product_index == $past(idx_ext[INDEX_W-1:0])))
    else $error("last result at unexpected index");

endmodule
